[sv/asl_pkg.sv]
package asl_pkg;

    localparam int TABLE_DEPTH_D   = 64;
    localparam int SECTION_BYTES_D = 65536;

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_LOOKUP = 3'd1;
    localparam logic [2:0] REQ_ADDR   = 3'd2;
    localparam logic [2:0] REQ_DELETE = 3'd3;
    localparam logic [2:0] REQ_EXCH   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_TBL_FULL  = 3'd2;
    localparam logic [2:0] ST_SEC_FULL  = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;
    localparam logic [2:0] ST_BAD_ALIGN = 3'd5;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] item_size;
        logic [6:0]  item_alignment;
        logic [31:0] first_id;
        logic [31:0] second_id;
        logic [5:0]  table_index;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] symbol_id;
        logic [6:0]  entry_index;
        logic [15:0] entry_offset;
        logic [15:0] entry_size;
        logic [31:0] entry_address;
        logic [16:0] total_size;
    } t_res;

endpackage

[sv/asl_ram.sv]
module asl_ram #(
    parameter int W = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/asl_place.sv]
module asl_place #(
    parameter int SECTION_BYTES = 65536,
    parameter int AW = 18
) (
    input  logic [AW-1:0] i_cur,
    input  logic [6:0]    i_align,
    input  logic [15:0]   i_size,
    output logic [AW-1:0] o_placed,
    output logic [AW-1:0] o_end,
    output logic          o_fail
);
    logic [AW-1:0] w_mask;

    assign w_mask   = AW'(i_align - 7'd1);
    assign o_placed = (i_cur + w_mask) & ~w_mask;
    assign o_end    = o_placed + AW'(i_size);
    assign o_fail   = (o_placed >= AW'(SECTION_BYTES)) || (o_end > AW'(SECTION_BYTES));
endmodule

[sv/aligned_symbol_layout_table.sv]
// Add and bad requests go from idle straight to the output state; address reads its entry first.
// Lookup and delete search the entries in order; delete then shifts each later entry down.
// Exchange: search for both ids, then two layout passes from the lower index to the last entry.
// Throughput: one request at a time, bounded by the single table read port.
// Reset: synchronous active low; clears count, used size, id counter, base, output valid.
module aligned_symbol_layout_table #(
    parameter int TABLE_DEPTH   = asl_pkg::TABLE_DEPTH_D,
    parameter int SECTION_BYTES = asl_pkg::SECTION_BYTES_D
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  asl_pkg::t_req i_in_word,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output asl_pkg::t_res o_out_word,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [31:0]   i_cfg_data
);
    import asl_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int OW = $clog2(SECTION_BYTES);
    localparam int UW = $clog2(SECTION_BYTES + 1);
    localparam int AW = ((OW > 16) ? OW : 16) + 2;

    typedef struct packed {
        logic [31:0]   id;
        logic [OW-1:0] off;
        logic [15:0]   size;
        logic [6:0]    al;
    } t_rec;
    localparam int RW = $bits(t_rec);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SRCH = 6'b000010,
        S_ADDR = 6'b000100,
        S_DEL  = 6'b001000,
        S_LAY  = 6'b010000,
        S_PUT  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_ptr, n_ptr, r_count, n_count, r_ia, n_ia, r_ib, n_ib;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [UW-1:0] r_used, n_used;
    logic [31:0]   r_idc, n_idc, r_base;
    t_req          r_req, n_req;
    t_rec          r_reca, n_reca, r_recb, n_recb;
    logic          r_fa, n_fa, r_fb, n_fb, r_first, n_first, r_pass, n_pass;
    logic [AW-1:0] r_cur, n_cur;
    logic [OW-1:0] r_delta, n_delta, w_dl;
    t_res          r_res, n_res, r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          w_we, w_last, w_hit_a, w_hit_b, w_bad_al;
    logic [IW-1:0] w_waddr;
    t_rec          w_wdata, w_d, w_src, w_rlo, w_rhi;
    logic [RW-1:0] w_rdata;
    logic [CW-1:0] w_tgt;
    logic [AW-1:0] p_cur, p_placed, p_end;
    logic [6:0]    p_al;
    logic [15:0]   p_size;
    logic          p_fail;

    function automatic t_res report(t_rec r, logic [CW-1:0] k);
        t_res x;
        x.status        = ST_OK;
        x.symbol_id     = r.id;
        x.entry_index   = 7'(k);
        x.entry_offset  = 16'(r.off);
        x.entry_size    = r.size;
        x.entry_address = r_base + 32'(r.off);
        x.total_size    = '0;
        return x;
    endfunction

    function automatic t_res none_res(logic [2:0] st, logic [6:0] k);
        t_res x;
        x             = '0;
        x.status      = st;
        x.entry_index = k;
        return x;
    endfunction

    asl_ram #(.W(RW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_ptr[IW-1:0]),
        .o_rdata (w_rdata)
    );

    asl_place #(.SECTION_BYTES(SECTION_BYTES), .AW(AW)) u_place (
        .i_cur    (p_cur),
        .i_align  (p_al),
        .i_size   (p_size),
        .o_placed (p_placed),
        .o_end    (p_end),
        .o_fail   (p_fail)
    );

    assign w_d      = t_rec'(w_rdata);
    assign w_rlo    = (r_ia < r_ib) ? r_reca : r_recb;
    assign w_rhi    = (r_ia < r_ib) ? r_recb : r_reca;
    assign w_src    = (r_ptr == r_lo) ? w_rhi : ((r_ptr == r_hi) ? w_rlo : w_d);
    assign w_tgt    = (r_ia == r_lo) ? r_hi : r_lo;
    assign w_last   = ((r_ptr + CW'(1)) == r_count);
    assign w_bad_al = (i_in_word.item_alignment == 7'd0) ||
                      ((i_in_word.item_alignment & (i_in_word.item_alignment - 7'd1)) != 7'd0);
    assign w_hit_a  = !r_fa && (w_d.id == r_req.first_id);
    assign w_hit_b  = !r_fb && (w_d.id == r_req.second_id);
    assign w_dl     = r_first ? ((w_d.off >= r_reca.off) ? w_d.off - r_reca.off : '0) : r_delta;

    always_comb begin
        if (r_state == S_LAY) begin
            p_cur  = r_cur;
            p_al   = (r_ptr == r_lo) ? 7'd1 : w_src.al;
            p_size = w_src.size;
        end else begin
            p_cur  = AW'(r_used);
            p_al   = i_in_word.item_alignment;
            p_size = i_in_word.item_size;
        end
    end

    always_comb begin
        n_state = r_state; n_ptr = r_ptr; n_count = r_count; n_used = r_used;
        n_idc = r_idc; n_req = r_req; n_fa = r_fa; n_fb = r_fb; n_ia = r_ia; n_ib = r_ib;
        n_reca = r_reca; n_recb = r_recb; n_lo = r_lo; n_hi = r_hi; n_cur = r_cur;
        n_delta = r_delta; n_first = r_first; n_pass = r_pass; n_res = r_res;
        n_out = r_out; n_out_valid = r_out_valid;
        w_we = 1'b0; w_waddr = r_ptr[IW-1:0]; w_wdata = w_d;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_word;
                    n_res = none_res(ST_OK, 7'(r_count));
                    n_fa = 1'b0; n_fb = 1'b0; n_ptr = '0; n_first = 1'b1; n_pass = 1'b0;
                    n_state = S_PUT;
                    case (i_in_word.req_type)
                        REQ_ADD: begin
                            if (w_bad_al) begin
                                n_res.status = ST_BAD_ALIGN;
                            end else if (r_count == CW'(TABLE_DEPTH)) begin
                                n_res.status = ST_TBL_FULL;
                            end else if (p_fail) begin
                                n_res.status = ST_SEC_FULL;
                            end else begin
                                w_we = 1'b1;
                                w_waddr = r_count[IW-1:0];
                                w_wdata = '{id: r_idc, off: OW'(p_placed),
                                            size: i_in_word.item_size,
                                            al: i_in_word.item_alignment};
                                n_used = UW'(p_end);
                                n_count = r_count + CW'(1);
                                n_idc = r_idc + 32'd1;
                                n_res = report(w_wdata, r_count);
                            end
                        end
                        REQ_LOOKUP, REQ_DELETE, REQ_EXCH: begin
                            if (r_count == '0) begin
                                n_res.status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        REQ_ADDR: begin
                            if (32'(i_in_word.table_index) >= 32'(r_count)) begin
                                n_res = none_res(ST_BAD_INDEX, {1'b0, i_in_word.table_index});
                            end else begin
                                n_ptr = CW'(i_in_word.table_index);
                                n_state = S_ADDR;
                            end
                        end
                        default: begin
                            n_res.status = ST_BAD_INDEX;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (w_hit_a) begin
                    n_fa = 1'b1; n_ia = r_ptr; n_reca = w_d;
                end
                if (w_hit_b) begin
                    n_fb = 1'b1; n_ib = r_ptr; n_recb = w_d;
                end
                if (r_req.req_type == REQ_EXCH) begin
                    if ((n_fa && n_fb) || w_last) begin
                        n_state = S_PUT;
                        if (!(n_fa && n_fb)) begin
                            n_res.status = ST_NOT_FOUND;
                        end else if (n_ia == n_ib) begin
                            n_res = report(n_reca, n_ia);
                        end else begin
                            n_lo = (n_ia < n_ib) ? n_ia : n_ib;
                            n_hi = (n_ia < n_ib) ? n_ib : n_ia;
                            n_ptr = n_lo;
                            n_cur = AW'((n_ia < n_ib) ? n_reca.off : n_recb.off);
                            n_state = S_LAY;
                        end
                    end else begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end else if (w_hit_a) begin
                    n_res = report(w_d, r_ptr);
                    n_state = S_PUT;
                    if (r_req.req_type == REQ_DELETE) begin
                        if (!w_last) begin
                            n_ptr = r_ptr + CW'(1);
                            n_state = S_DEL;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_used = (r_used >= UW'(w_d.off)) ? UW'(w_d.off) : r_used;
                        end
                    end
                end else if (w_last) begin
                    n_res.status = ST_NOT_FOUND;
                    n_state = S_PUT;
                end else begin
                    n_ptr = r_ptr + CW'(1);
                end
            end
            S_DEL: begin
                n_delta = w_dl;
                n_first = 1'b0;
                w_we = 1'b1;
                w_waddr = IW'(r_ptr - CW'(1));
                w_wdata = '{id: w_d.id, off: w_d.off - w_dl, size: w_d.size, al: w_d.al};
                if (w_last) begin
                    n_count = r_count - CW'(1);
                    n_used = (r_used >= UW'(w_dl)) ? r_used - UW'(w_dl) : '0;
                    n_state = S_PUT;
                end else begin
                    n_ptr = r_ptr + CW'(1);
                end
            end
            S_ADDR: begin
                n_res = report(w_d, r_ptr);
                n_state = S_PUT;
            end
            S_LAY: begin
                if (!r_pass) begin
                    if (p_fail) begin
                        n_res.status = ST_SEC_FULL;
                        n_state = S_PUT;
                    end else if (w_last) begin
                        n_pass = 1'b1;
                        n_ptr = r_lo;
                        n_cur = AW'(w_rlo.off);
                    end else begin
                        n_cur = p_end;
                        n_ptr = r_ptr + CW'(1);
                    end
                end else begin
                    w_we = 1'b1;
                    w_wdata = '{id: w_src.id, off: OW'(p_placed), size: w_src.size,
                                al: w_src.al};
                    if (r_ptr == w_tgt) begin
                        n_res = report(w_wdata, r_ptr);
                    end
                    n_cur = p_end;
                    if (w_last) begin
                        n_used = UW'(p_end);
                        n_state = S_PUT;
                    end else begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end
            end
            S_PUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out = r_res;
                    n_out.total_size = 17'(r_used);
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_used <= '0;
            r_idc <= '0;
            r_base <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_used <= n_used;
            r_idc <= n_idc;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr; r_req <= n_req; r_fa <= n_fa; r_fb <= n_fb;
        r_ia <= n_ia; r_ib <= n_ib; r_reca <= n_reca; r_recb <= n_recb;
        r_lo <= n_lo; r_hi <= n_hi; r_cur <= n_cur; r_delta <= n_delta;
        r_first <= n_first; r_pass <= n_pass; r_res <= n_res; r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;
endmodule

[sv/asl_checker.sv]
module asl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input asl_pkg::t_res o_out_word
);
    import asl_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or busy after reset");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted word did not make the block busy");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.status <= ST_BAD_ALIGN)
        else $error("status code out of range");
endmodule

bind aligned_symbol_layout_table asl_checker u_asl_checker (.*);
